### design/packet_loss_pattern_emulator_assert.svh
// Assertion macros shared by the packet loss emulator RTL.
`ifndef PACKET_LOSS_PATTERN_EMULATOR_ASSERT_SVH
`define PACKET_LOSS_PATTERN_EMULATOR_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define PLPE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define PLPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/plpe_pkg.sv
// Package: types and constants of the packet loss pattern emulator.
package plpe_pkg;

  localparam int unsigned CountWidth     = 32;
  localparam int unsigned ByteCountWidth = 48;
  localparam int unsigned SizeWidth      = 16;
  localparam int unsigned RandWidth      = 16;
  localparam int unsigned RateWidth      = 17;
  localparam int unsigned BurstWidth     = 8;
  localparam int unsigned CycleWidth     = 16;
  localparam int unsigned RunWidth       = 16;
  localparam int unsigned CfgIdxWidth    = 3;
  localparam int unsigned CfgDataWidth   = 17;
  localparam int unsigned StepWidth      = $clog2(RandWidth);

  // Loss patterns
  typedef enum logic [2:0] {
    PAT_UNIFORM  = 3'd0,
    PAT_BURST    = 3'd1,
    PAT_PERIODIC = 3'd2,
    PAT_RANDOM   = 3'd3,
    PAT_ADAPTIVE = 3'd4
  } pattern_e;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_LOSS_PATTERN  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LOSS_RATE     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BURST_CHANCE  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BURST_LEN_MIN = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_BURST_LEN_MAX = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_CYCLE_LENGTH  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_CYCLE_DROPS   = 3'd6;

  // Reset values
  localparam logic [2:0]            RST_LOSS_PATTERN  = 3'd0;
  localparam logic [RateWidth-1:0]  RST_LOSS_RATE     = 17'd6554;
  localparam logic [RateWidth-1:0]  RST_BURST_CHANCE  = 17'd3277;
  localparam logic [BurstWidth-1:0] RST_BURST_LEN_MIN = 8'd3;
  localparam logic [BurstWidth-1:0] RST_BURST_LEN_MAX = 8'd10;
  localparam logic [CycleWidth-1:0] RST_CYCLE_LENGTH  = 16'd100;
  localparam logic [CycleWidth-1:0] RST_CYCLE_DROPS   = 16'd10;

  // Rate constants, Q1.16
  localparam logic [RateWidth-1:0]   ONE_Q16  = 17'd65536;
  localparam logic [RateWidth:0]     HALF_Q16 = 18'd32768;
  localparam logic [RunWidth-1:0]    KEEP_LIMIT = 16'd50;
  localparam logic [RunWidth-1:0]    DROP_LIMIT = 16'd10;
  localparam logic [RunWidth-1:0]    RUN_MAX    = 16'hFFFF;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_COMMIT
  } state_e;

endpackage

### design/packet_loss_pattern_emulator.sv
// Top level: per-packet drop decision engine with running loss totals.
//
// Packet loss pattern emulator. Each accepted item (packet size plus two
// random words) yields exactly one result: the drop decision, the running
// totals of packets seen, packets dropped and bytes dropped after this
// packet, and whether burst packets are still pending. Five modes come from
// the loss_pattern register: uniform and random (drop when rand_rate is
// below loss_rate), burst (start a burst when rand_rate is below
// burst_chance, length = min + rand_size mod span, then drop the rest of the
// burst), periodic (drop the first cycle_drops packets of every cycle_length
// packets) and adaptive (double the rate, capped at one half, after more
// than 50 straight keeps; halve it after more than 10 straight drops).
// Rates are Q1.16, 65536 meaning always. An item is accepted in S_IDLE and
// committed in S_COMMIT; one that starts a burst also passes through S_MOD,
// as the burst length remainder runs through a restoring remainder unit one
// bit of rand_size per cycle (16 steps). The input stalls while an item is in
// flight. The result sits in an output register, so the next item is accepted
// while a result still waits; the commit of that next item waits for the slot
// to free. Configuration writes take effect at once; the user must make them
// only while the block is idle, which the block does not enforce. Writing
// loss_pattern clears the burst and period state, writing cycle_length or
// cycle_drops clears the period position. Totals wrap; run counters saturate.
module packet_loss_pattern_emulator
  import plpe_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [CfgDataWidth-1:0]    cfg_wdata_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SizeWidth-1:0]       packet_size_i,
  input  logic [RandWidth-1:0]       rand_rate_i,
  input  logic [RandWidth-1:0]       rand_size_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       drop_o,
  output logic [CountWidth-1:0]      packets_seen_o,
  output logic [CountWidth-1:0]      packets_dropped_o,
  output logic [ByteCountWidth-1:0]  bytes_dropped_o,
  output logic                       burst_active_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [2:0]            pattern_q;
  logic [RateWidth-1:0]  loss_rate_q, burst_chance_q;
  logic [BurstWidth-1:0] len_min_q, len_max_q;
  logic [CycleWidth-1:0] cycle_length_q, cycle_drops_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      <= RST_LOSS_PATTERN;
      loss_rate_q    <= RST_LOSS_RATE;
      burst_chance_q <= RST_BURST_CHANCE;
      len_min_q      <= RST_BURST_LEN_MIN;
      len_max_q      <= RST_BURST_LEN_MAX;
      cycle_length_q <= RST_CYCLE_LENGTH;
      cycle_drops_q  <= RST_CYCLE_DROPS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOSS_PATTERN:  pattern_q      <= cfg_wdata_i[2:0];
        REG_LOSS_RATE:     loss_rate_q    <= cfg_wdata_i;
        REG_BURST_CHANCE:  burst_chance_q <= cfg_wdata_i;
        REG_BURST_LEN_MIN: len_min_q      <= cfg_wdata_i[BurstWidth-1:0];
        REG_BURST_LEN_MAX: len_max_q      <= cfg_wdata_i[BurstWidth-1:0];
        REG_CYCLE_LENGTH:  cycle_length_q <= cfg_wdata_i[CycleWidth-1:0];
        REG_CYCLE_DROPS:   cycle_drops_q  <= cfg_wdata_i[CycleWidth-1:0];
        default: ;
      endcase
    end
  end

  // Config writes that reset burst / period state
  logic clr_burst, clr_period;
  assign clr_burst  = cfg_we_i && (cfg_index_i == REG_LOSS_PATTERN);
  assign clr_period = cfg_we_i && ((cfg_index_i == REG_LOSS_PATTERN) ||
                                   (cfg_index_i == REG_CYCLE_LENGTH) ||
                                   (cfg_index_i == REG_CYCLE_DROPS));

  // Burst length bounds: zero minimum counts as one, inverted range gives span one
  logic [BurstWidth-1:0] len_lo, span;
  always_comb begin
    len_lo = (len_min_q == '0) ? BurstWidth'(1) : len_min_q;
    span   = (len_max_q >= len_lo) ? (len_max_q - len_lo + BurstWidth'(1))
                                   : BurstWidth'(1);
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic   accept, slot_free, commit, mod_run, need_mod;

  logic [BurstWidth-1:0] burst_left_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_o || !out_stall_i;
  // Only a packet that starts a burst needs the remainder unit
  assign need_mod  = (pattern_q == PAT_BURST) && (burst_left_q == '0) &&
                     ({1'b0, rand_rate_i} < burst_chance_q);

  logic [StepWidth-1:0] step_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = need_mod ? S_MOD : S_COMMIT;
      end
      S_MOD: begin
        if (step_q == '0) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mod_run    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_MOD:    mod_run    = 1'b1;
      S_COMMIT: commit     = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------------
  // Item latch and remainder unit (rand_size mod span, one bit/cycle)
  // ---------------------------------------------------------------------
  logic [SizeWidth-1:0]  size_q;
  logic [RandWidth-1:0]  rnd_q, rsz_q;
  logic [BurstWidth-1:0] rem_q, rem_d;
  logic [BurstWidth:0]   trial;

  always_comb begin
    trial = {rem_q, rsz_q[step_q]};
    rem_d = (trial >= {1'b0, span}) ? BurstWidth'(trial - {1'b0, span})
                                    : trial[BurstWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= packet_size_i;
      rnd_q  <= rand_rate_i;
      rsz_q  <= rand_size_i;
      rem_q  <= '0;
      step_q <= StepWidth'(RandWidth - 1);
    end else if (mod_run) begin
      rem_q  <= rem_d;
      step_q <= step_q - StepWidth'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Decision and state update
  // ---------------------------------------------------------------------
  logic [CycleWidth-1:0]     cycle_pos_q;
  logic [RunWidth-1:0]       run_drops_q, run_keeps_q;
  logic [CountWidth-1:0]     seen_q, dropped_q;
  logic [ByteCountWidth-1:0] bytes_q;

  logic                  drop_d;
  logic [BurstWidth-1:0] burst_left_d;
  logic [CycleWidth-1:0] cycle_pos_d;
  logic [CycleWidth:0]   pos_next;
  logic [RateWidth:0]    rate_dbl;
  logic                  rate_hit;

  // Plain rate test: a rate above one never drops
  assign rate_hit = (loss_rate_q <= ONE_Q16) && ({1'b0, rnd_q} < loss_rate_q);

  always_comb begin
    drop_d       = 1'b0;
    burst_left_d = burst_left_q;
    cycle_pos_d  = cycle_pos_q;
    pos_next     = {1'b0, cycle_pos_q} + (CycleWidth+1)'(1);
    rate_dbl     = {loss_rate_q, 1'b0};
    if (rate_dbl > HALF_Q16) rate_dbl = HALF_Q16;
    case (pattern_q)
      PAT_BURST: begin
        if (burst_left_q != '0) begin
          drop_d       = 1'b1;
          burst_left_d = burst_left_q - BurstWidth'(1);
        end else if ({1'b0, rnd_q} < burst_chance_q) begin
          drop_d       = 1'b1;
          burst_left_d = len_lo + rem_q - BurstWidth'(1);
        end
      end
      PAT_PERIODIC: begin
        drop_d      = cycle_pos_q < cycle_drops_q;
        cycle_pos_d = (pos_next >= {1'b0, cycle_length_q}) ? '0
                                                            : pos_next[CycleWidth-1:0];
      end
      PAT_ADAPTIVE: begin
        if (run_keeps_q > KEEP_LIMIT)      drop_d = {2'b0, rnd_q} < rate_dbl;
        else if (run_drops_q > DROP_LIMIT) drop_d = {rnd_q, 1'b0} < loss_rate_q;
        else                               drop_d = rate_hit;
      end
      default: drop_d = rate_hit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_left_q <= '0;
      cycle_pos_q  <= '0;
      run_drops_q  <= '0;
      run_keeps_q  <= '0;
      seen_q       <= '0;
      dropped_q    <= '0;
      bytes_q      <= '0;
      drop_o       <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      if (clr_burst) burst_left_q <= '0;
      if (clr_period) cycle_pos_q <= '0;
      if (commit) begin
        burst_left_q <= burst_left_d;
        cycle_pos_q  <= cycle_pos_d;
        seen_q       <= seen_q + CountWidth'(1);
        drop_o       <= drop_d;
        if (drop_d) begin
          dropped_q   <= dropped_q + CountWidth'(1);
          bytes_q     <= bytes_q + ByteCountWidth'(size_q);
          if (run_drops_q != RUN_MAX) run_drops_q <= run_drops_q + RunWidth'(1);
          run_keeps_q <= '0;
        end else begin
          if (run_keeps_q != RUN_MAX) run_keeps_q <= run_keeps_q + RunWidth'(1);
          run_drops_q <= '0;
        end
      end
      // Hold the result until taken
      if (commit)                          out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // Totals only move at commit, so they double as the result payload
  assign packets_seen_o    = seen_q;
  assign packets_dropped_o = dropped_q;
  assign bytes_dropped_o   = bytes_q;
  assign burst_active_o    = burst_left_q != '0;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `include "packet_loss_pattern_emulator_assert.svh"

  `PLPE_ASSERT_NOW(a_rem_below_span, state_q == S_COMMIT, rem_q < span, "remainder not below span")
  `PLPE_ASSERT_NEXT(a_keep_holds_drops, commit && !drop_d, $stable(dropped_q), "drop count moved on a keep")
  `PLPE_ASSERT_NOW(a_burst_tail_drops, commit && pattern_q == PAT_BURST && burst_left_q != '0, drop_d, "pending burst packet kept")
  `PLPE_ASSERT_NOW(a_period_pos_range, cycle_length_q != '0, cycle_pos_q < cycle_length_q, "period position out of range")

endmodule
